FILE: design/fpjb_pkg.sv
// Shared constants and types for the pair-parity FEC jitter buffer.
package fpjb_pkg;

	localparam int FRAMES        = 1024;
	localparam int PAYLOAD_WORDS = 20;

	localparam int SEQ_W        = 32;
	localparam int DATA_W       = 64;
	localparam int WORD_INDEX_W = 5;
	localparam int FEC_BIT      = 31;

	localparam int IDX_W   = $clog2(FRAMES);
	localparam int PAIR_W  = IDX_W - 1;
	localparam int PAIRS   = (FRAMES + 1) / 2;
	localparam int DEPTH   = FRAMES * PAYLOAD_WORDS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int WIDX_W  = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
	localparam int CNT_W   = $clog2(PAYLOAD_WORDS + 1);

	typedef struct packed {
		logic parity_odd;
		logic parity_even;
		logic media_odd;
		logic media_even;
	} pair_row_t;

endpackage

FILE: design/fec_pair_jitter_buffer.sv
// Top level of the pair-parity FEC jitter buffer with its stores and sequencer.
// Media words are taken one per cycle while idle; a committed packet holds the input through
// a valid-table read, a copy of each word and a valid-table update, and, when a pair is
// rebuilt, through a read and a write of each word through the XOR unit.
// A playout request reads the valid table, then reads and presents each word in turn, waiting on out_ready.
// After reset a clearing pass writes the valid table, one pair row per cycle, all 512 rows.
module fec_pair_jitter_buffer (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    func,
	input  logic [fpjb_pkg::SEQ_W-1:0]              seq_header,
	input  logic [fpjb_pkg::DATA_W-1:0]             payload_word,
	input  logic                                    last_word,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [fpjb_pkg::SEQ_W-1:0]              frame_seq,
	output logic [fpjb_pkg::WORD_INDEX_W-1:0]       word_index,
	output logic [fpjb_pkg::DATA_W-1:0]             frame_word,
	output logic                                    frame_missing,
	output logic                                    end_of_frame
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VRD,
		ST_COPY,
		ST_VUPD,
		ST_RB_RD,
		ST_RB_WR,
		ST_P_VRD,
		ST_P_RD,
		ST_P_OUT
	} state_t;

	localparam logic [fpjb_pkg::ADDR_W-1:0] PW_A =
		fpjb_pkg::ADDR_W'(fpjb_pkg::PAYLOAD_WORDS);
	localparam logic [fpjb_pkg::WIDX_W-1:0] W_LAST =
		fpjb_pkg::WIDX_W'(fpjb_pkg::PAYLOAD_WORDS - 1);
	localparam logic [fpjb_pkg::CNT_W-1:0] CNT_FULL =
		fpjb_pkg::CNT_W'(fpjb_pkg::PAYLOAD_WORDS);
	localparam logic [fpjb_pkg::PAIR_W-1:0] CLR_LAST =
		fpjb_pkg::PAIR_W'(fpjb_pkg::PAIRS - 1);

	state_t                          state_q;
	logic [fpjb_pkg::PAIR_W-1:0]     clr_q;
	logic [fpjb_pkg::CNT_W-1:0]      cnt_q;
	logic [fpjb_pkg::WIDX_W-1:0]     w_q;
	logic                            fec_q;
	logic [fpjb_pkg::IDX_W-1:0]      idx_q;
	logic [fpjb_pkg::ADDR_W-1:0]     base_q;
	logic [fpjb_pkg::ADDR_W-1:0]     src_base_q;
	logic [fpjb_pkg::ADDR_W-1:0]     dst_base_q;
	logic [fpjb_pkg::ADDR_W-1:0]     par_base_q;
	logic [fpjb_pkg::SEQ_W-1:0]      playout_q;
	logic [fpjb_pkg::DATA_W-1:0]     staging_q [fpjb_pkg::PAYLOAD_WORDS];

	logic                            out_valid_q;
	logic [fpjb_pkg::SEQ_W-1:0]      frame_seq_q;
	logic [fpjb_pkg::WORD_INDEX_W-1:0] word_index_q;
	logic [fpjb_pkg::DATA_W-1:0]     frame_word_q;
	logic                            frame_missing_q;
	logic                            end_of_frame_q;

	logic [fpjb_pkg::DATA_W-1:0]     media_mem  [fpjb_pkg::DEPTH];
	logic [fpjb_pkg::DATA_W-1:0]     parity_mem [fpjb_pkg::DEPTH];
	fpjb_pkg::pair_row_t             valid_mem  [fpjb_pkg::PAIRS];
	logic [fpjb_pkg::DATA_W-1:0]     mrd_q;
	logic [fpjb_pkg::DATA_W-1:0]     prd_q;
	fpjb_pkg::pair_row_t             vrd_q;

	logic                            in_fire;
	logic                            out_fire;
	logic                            out_load;
	logic [fpjb_pkg::CNT_W-1:0]      cnt_inc;
	logic                            commit_go;
	logic [fpjb_pkg::IDX_W-1:0]      mul_idx;
	logic [fpjb_pkg::ADDR_W-1:0]     mul_out;
	fpjb_pkg::pair_row_t             new_row;
	logic                            odd_ok;
	logic                            rebuild_go;
	logic [fpjb_pkg::ADDR_W-1:0]     even_base;
	logic                            play_in_range;
	logic                            have;

	logic                            media_we;
	logic [fpjb_pkg::ADDR_W-1:0]     media_waddr;
	logic [fpjb_pkg::DATA_W-1:0]     media_wdata;
	logic                            media_re;
	logic [fpjb_pkg::ADDR_W-1:0]     media_raddr;
	logic                            parity_we;
	logic                            parity_re;
	logic                            valid_we;
	logic [fpjb_pkg::PAIR_W-1:0]     valid_waddr;
	fpjb_pkg::pair_row_t             valid_wdata;
	logic                            valid_re;
	logic [fpjb_pkg::PAIR_W-1:0]     valid_raddr;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;
	assign out_load = (state_q == ST_P_OUT) && (!out_valid_q || out_ready);

	assign cnt_inc   = (cnt_q < CNT_FULL) ? cnt_q + 1'b1 : cnt_q;
	assign commit_go = in_fire && !func && last_word && (cnt_inc == CNT_FULL) &&
		(seq_header[fpjb_pkg::FEC_BIT-1:0] < fpjb_pkg::FEC_BIT'(fpjb_pkg::FRAMES));

	// One constant multiplier forms the word base of either a committed or a played frame.
	assign mul_idx = func ? playout_q[fpjb_pkg::IDX_W-1:0] : seq_header[fpjb_pkg::IDX_W-1:0];
	assign mul_out = fpjb_pkg::ADDR_W'(mul_idx) * PW_A;

	assign play_in_range = (playout_q < fpjb_pkg::SEQ_W'(fpjb_pkg::FRAMES));
	assign have = play_in_range && (playout_q[0] ? vrd_q.media_odd : vrd_q.media_even);

	assign odd_ok = ({1'b0, idx_q[fpjb_pkg::IDX_W-1:1], 1'b1} <
		(fpjb_pkg::IDX_W + 1)'(fpjb_pkg::FRAMES));
	assign even_base = base_q - (idx_q[0] ? PW_A : '0);

	always_comb begin
		new_row = vrd_q;
		case ({fec_q, idx_q[0]})
			2'b00:   new_row.media_even  = 1'b1;
			2'b01:   new_row.media_odd   = 1'b1;
			2'b10:   new_row.parity_even = 1'b1;
			default: new_row.parity_odd  = 1'b1;
		endcase
		rebuild_go = odd_ok && new_row.parity_odd && (new_row.media_even ^ new_row.media_odd);
		if (rebuild_go) begin
			new_row.media_even = 1'b1;
			new_row.media_odd  = 1'b1;
		end
	end

	always_comb begin
		media_we    = 1'b0;
		media_waddr = base_q + fpjb_pkg::ADDR_W'(w_q);
		media_wdata = staging_q[w_q];
		media_re    = 1'b0;
		media_raddr = base_q + fpjb_pkg::ADDR_W'(w_q);
		parity_we   = 1'b0;
		parity_re   = 1'b0;
		valid_we    = 1'b0;
		valid_waddr = idx_q[fpjb_pkg::IDX_W-1:1];
		valid_wdata = new_row;
		valid_re    = 1'b0;
		valid_raddr = idx_q[fpjb_pkg::IDX_W-1:1];
		unique case (state_q)
			ST_CLEAR: begin
				valid_we    = 1'b1;
				valid_waddr = clr_q;
				valid_wdata = '0;
			end
			ST_VRD: begin
				valid_re = 1'b1;
			end
			ST_COPY: begin
				media_we  = !fec_q;
				parity_we = fec_q;
			end
			ST_VUPD: begin
				valid_we = 1'b1;
			end
			ST_RB_RD: begin
				media_re    = 1'b1;
				media_raddr = src_base_q + fpjb_pkg::ADDR_W'(w_q);
				parity_re   = 1'b1;
			end
			ST_RB_WR: begin
				media_we    = 1'b1;
				media_waddr = dst_base_q + fpjb_pkg::ADDR_W'(w_q);
				media_wdata = mrd_q ^ prd_q;
			end
			ST_P_VRD: begin
				valid_re    = 1'b1;
				valid_raddr = playout_q[fpjb_pkg::IDX_W-1:1];
			end
			ST_P_RD: begin
				media_re = have;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (media_we) begin
			media_mem[media_waddr] <= media_wdata;
		end
		if (media_re) begin
			mrd_q <= media_mem[media_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (parity_we) begin
			parity_mem[base_q + fpjb_pkg::ADDR_W'(w_q)] <= staging_q[w_q];
		end
		if (parity_re) begin
			prd_q <= parity_mem[par_base_q + fpjb_pkg::ADDR_W'(w_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_we) begin
			valid_mem[valid_waddr] <= valid_wdata;
		end
		if (valid_re) begin
			vrd_q <= valid_mem[valid_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !func && (cnt_q < CNT_FULL)) begin
			staging_q[cnt_q[fpjb_pkg::WIDX_W-1:0]] <= payload_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			w_q         <= '0;
			playout_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						base_q <= mul_out;
						w_q    <= '0;
						if (func) begin
							state_q <= ST_P_VRD;
						end else begin
							cnt_q <= last_word ? '0 : cnt_inc;
							fec_q <= seq_header[fpjb_pkg::FEC_BIT];
							idx_q <= seq_header[fpjb_pkg::IDX_W-1:0];
							if (commit_go) begin
								state_q <= ST_VRD;
							end
						end
					end
				end
				ST_VRD: begin
					state_q <= ST_COPY;
				end
				ST_COPY: begin
					w_q <= w_q + 1'b1;
					if (w_q == W_LAST) begin
						state_q <= ST_VUPD;
					end
				end
				ST_VUPD: begin
					w_q        <= '0;
					par_base_q <= even_base + PW_A;
					if (vrd_q.media_even || (!fec_q && !idx_q[0])) begin
						src_base_q <= even_base;
						dst_base_q <= even_base + PW_A;
					end else begin
						src_base_q <= even_base + PW_A;
						dst_base_q <= even_base;
					end
					state_q <= rebuild_go ? ST_RB_RD : ST_IDLE;
				end
				ST_RB_RD: begin
					state_q <= ST_RB_WR;
				end
				ST_RB_WR: begin
					w_q <= w_q + 1'b1;
					state_q <= (w_q == W_LAST) ? ST_IDLE : ST_RB_RD;
				end
				ST_P_VRD: begin
					state_q <= ST_P_RD;
				end
				ST_P_RD: begin
					state_q <= ST_P_OUT;
				end
				ST_P_OUT: begin
					if (out_load) begin
						frame_seq_q     <= playout_q;
						word_index_q    <= fpjb_pkg::WORD_INDEX_W'(w_q);
						frame_word_q    <= have ? mrd_q : '0;
						frame_missing_q <= !have;
						end_of_frame_q  <= (w_q == W_LAST);
						w_q             <= w_q + 1'b1;
						if (w_q == W_LAST) begin
							playout_q <= playout_q + 1'b1;
							state_q   <= ST_IDLE;
						end else begin
							state_q <= ST_P_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_seq     = frame_seq_q;
	assign word_index    = word_index_q;
	assign frame_word    = frame_word_q;
	assign frame_missing = frame_missing_q;
	assign end_of_frame  = end_of_frame_q;

	a_eof_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_frame) |-> (word_index == fpjb_pkg::WORD_INDEX_W'(W_LAST)))
		else $error("end of frame flagged away from the last word");

	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_missing) |-> (frame_word == '0))
		else $error("missing frame carries nonzero data");

	a_rebuild_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RB_RD && $past(state_q) != ST_RB_WR) |-> ($past(state_q) == ST_VUPD))
		else $error("rebuild entered without a valid-table update");

	a_rebuild_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RB_RD || state_q == ST_RB_WR) |-> (dst_base_q != src_base_q))
		else $error("rebuild source and destination frames coincide");

endmodule
